// ----- hdl/lsfe_pkg.sv -----
// lsfe_pkg: shared types and constants for the LSB stego frame extractor.
// Depends on nothing; every other file of the block except lsfe_if.sv refers to it by scoped names.
`default_nettype none

package lsfe_pkg;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CFG_MAGIC_WORD   = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_HEADER_BYTES = 1'b1;
  localparam int unsigned CfgDataW = 16;

  // Reset values of the configuration registers
  localparam logic [15:0] MAGIC_RESET  = 16'd9002;
  localparam logic [7:0]  HEADER_RESET = 8'd54;

  // Last bit index of each field, counted from zero
  localparam logic [4:0] MAGIC_LAST_BIT = 5'd15;
  localparam logic [4:0] LEN_LAST_BIT   = 5'd31;
  localparam logic [4:0] BYTE_LAST_BIT  = 5'd7;

  // Parser phase
  typedef enum logic [2:0] {
    PH_SKIP      = 3'd0,
    PH_MAGIC     = 3'd1,
    PH_EXT_LEN   = 3'd2,
    PH_EXT_BYTES = 3'd3,
    PH_PAY_LEN   = 3'd4,
    PH_PAY_BYTES = 3'd5,
    PH_DONE      = 3'd6,
    PH_ERROR     = 3'd7
  } phase_t;

  // Result kind codes
  typedef enum logic [2:0] {
    K_MAGIC_OK  = 3'd0,
    K_MAGIC_BAD = 3'd1,
    K_EXT_LEN   = 3'd2,
    K_EXT_BYTE  = 3'd3,
    K_PAY_LEN   = 3'd4,
    K_PAY_BYTE  = 3'd5
  } kind_t;

  // One result beat as it leaves the decoder
  typedef struct packed {
    kind_t       kind;
    logic [31:0] value;
    logic        last;
  } result_t;

endpackage

`default_nettype wire

// ----- hdl/lsfe_if.sv -----
// lsfe_in_if / lsfe_out_if: valid/ready channels of the frame extractor.
// Depends on nothing; payload widths follow the file-byte and result formats.
`default_nettype none

interface lsfe_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] image_byte;
  logic       first_byte;

  modport source (output valid, output image_byte, output first_byte, input ready);
  modport sink   (input valid, input image_byte, input first_byte, output ready);
endinterface

interface lsfe_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [31:0] value;
  logic        last;

  modport source (output valid, output kind, output value, output last, input ready);
  modport sink   (input valid, input kind, input value, input last, output ready);
endinterface

`default_nettype wire

// ----- hdl/lsfe_decoder.sv -----
// lsfe_decoder: configuration registers, parse state and per-byte field decode.
// Depends on lsfe_pkg; feeds lsfe_out_reg with one result per completed field.
`default_nettype none

module lsfe_decoder (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [lsfe_pkg::CfgIdxW-1:0]   cfg_index,
  input  wire logic [lsfe_pkg::CfgDataW-1:0]  cfg_wdata,
  input  wire logic                           beat_acc,
  input  wire logic [7:0]                     image_byte,
  input  wire logic                           first_byte,
  output lsfe_pkg::result_t                   res,
  output logic                                res_emit
);

  logic [15:0]      magic_word_r;
  logic [7:0]       header_bytes_r;
  lsfe_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]       hdr_cnt_r, hdr_cnt_nxt;
  logic [31:0]      acc_r, acc_nxt;
  logic [4:0]       bit_cnt_r, bit_cnt_nxt;
  logic [31:0]      remain_r, remain_nxt;

  // state as seen by this beat, after an optional restart
  lsfe_pkg::phase_t ph;
  logic [7:0]       hc;
  logic [31:0]      acc;
  logic [4:0]       bc;
  logic [31:0]      rem;
  logic [31:0]      word;
  logic [31:0]      len;
  logic [31:0]      rem_dec;
  logic [4:0]       last_bit;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_word_r   <= lsfe_pkg::MAGIC_RESET;
      header_bytes_r <= lsfe_pkg::HEADER_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lsfe_pkg::CFG_MAGIC_WORD:   magic_word_r   <= cfg_wdata;
        lsfe_pkg::CFG_HEADER_BYTES: header_bytes_r <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // Decode of one file byte
  always_comb begin
    ph  = first_byte ? lsfe_pkg::PH_SKIP : phase_r;
    hc  = first_byte ? 8'd0  : hdr_cnt_r;
    acc = first_byte ? 32'd0 : acc_r;
    bc  = first_byte ? 5'd0  : bit_cnt_r;
    rem = first_byte ? 32'd0 : remain_r;

    phase_nxt   = ph;
    hdr_cnt_nxt = hc;
    acc_nxt     = acc;
    bit_cnt_nxt = bc;
    remain_nxt  = rem;
    res_emit    = 1'b0;
    res.kind    = lsfe_pkg::K_MAGIC_OK;
    res.value   = 32'd0;
    res.last    = 1'b0;
    word        = 32'd0;
    len         = 32'd0;
    rem_dec     = rem - 32'd1;
    last_bit    = lsfe_pkg::BYTE_LAST_BIT;

    // header skip, then drop into the magic field on the same byte
    if (ph == lsfe_pkg::PH_SKIP) begin
      if (hc < header_bytes_r) begin
        hdr_cnt_nxt = hc + 8'd1;
      end else begin
        ph = lsfe_pkg::PH_MAGIC;
        phase_nxt = lsfe_pkg::PH_MAGIC;
        acc = 32'd0;
        bc  = 5'd0;
      end
    end

    if (ph != lsfe_pkg::PH_SKIP && ph != lsfe_pkg::PH_DONE && ph != lsfe_pkg::PH_ERROR) begin
      word = {acc[30:0], image_byte[0]};
      len  = word[31] ? 32'd0 : word;
      if (ph == lsfe_pkg::PH_MAGIC) begin
        last_bit = lsfe_pkg::MAGIC_LAST_BIT;
      end else if (ph == lsfe_pkg::PH_EXT_LEN || ph == lsfe_pkg::PH_PAY_LEN) begin
        last_bit = lsfe_pkg::LEN_LAST_BIT;
      end
      if (bc != last_bit) begin
        acc_nxt     = word;
        bit_cnt_nxt = bc + 5'd1;
      end else begin
        acc_nxt     = 32'd0;
        bit_cnt_nxt = 5'd0;
        res_emit    = 1'b1;
        unique case (ph)
          lsfe_pkg::PH_MAGIC: begin
            if (word[15:0] == magic_word_r) begin
              phase_nxt = lsfe_pkg::PH_EXT_LEN;
            end else begin
              phase_nxt = lsfe_pkg::PH_ERROR;
              res.kind  = lsfe_pkg::K_MAGIC_BAD;
              res.last  = 1'b1;
            end
          end
          lsfe_pkg::PH_EXT_LEN: begin
            remain_nxt = len;
            phase_nxt  = (len == 32'd0) ? lsfe_pkg::PH_PAY_LEN : lsfe_pkg::PH_EXT_BYTES;
            res.kind   = lsfe_pkg::K_EXT_LEN;
            res.value  = len;
          end
          lsfe_pkg::PH_EXT_BYTES: begin
            remain_nxt = rem_dec;
            if (rem_dec == 32'd0) phase_nxt = lsfe_pkg::PH_PAY_LEN;
            res.kind   = lsfe_pkg::K_EXT_BYTE;
            res.value  = {24'd0, word[7:0]};
          end
          lsfe_pkg::PH_PAY_LEN: begin
            remain_nxt = len;
            phase_nxt  = (len == 32'd0) ? lsfe_pkg::PH_DONE : lsfe_pkg::PH_PAY_BYTES;
            res.kind   = lsfe_pkg::K_PAY_LEN;
            res.value  = len;
          end
          default: begin
            remain_nxt = rem_dec;
            res.kind   = lsfe_pkg::K_PAY_BYTE;
            res.value  = {24'd0, word[7:0]};
            if (rem_dec == 32'd0) begin
              phase_nxt = lsfe_pkg::PH_DONE;
              res.last  = 1'b1;
            end
          end
        endcase
      end
    end
  end

  // Parse state advances only on an accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= lsfe_pkg::PH_SKIP;
      hdr_cnt_r <= 8'd0;
      acc_r     <= 32'd0;
      bit_cnt_r <= 5'd0;
      remain_r  <= 32'd0;
    end else if (beat_acc) begin
      phase_r   <= phase_nxt;
      hdr_cnt_r <= hdr_cnt_nxt;
      acc_r     <= acc_nxt;
      bit_cnt_r <= bit_cnt_nxt;
      remain_r  <= remain_nxt;
    end
  end

  // error and done are sticky until a new file starts
  a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == lsfe_pkg::PH_ERROR && !(beat_acc && first_byte))
      |=> phase_r == lsfe_pkg::PH_ERROR)
    else $error("error phase left without restart");

  // magic field never counts past its sixteenth bit
  a_magic_count: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == lsfe_pkg::PH_MAGIC |-> bit_cnt_r <= lsfe_pkg::MAGIC_LAST_BIT)
    else $error("magic bit count overran");

  // a mismatch result always closes the file
  a_bad_last: assert property (@(posedge clk) disable iff (!rst_n)
    (res_emit && res.kind == lsfe_pkg::K_MAGIC_BAD) |-> res.last)
    else $error("magic mismatch without last");

  // byte phases always carry a nonzero count
  a_remain_nz: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == lsfe_pkg::PH_EXT_BYTES || phase_r == lsfe_pkg::PH_PAY_BYTES)
      |-> remain_r != 32'd0)
    else $error("byte phase with zero remaining");

endmodule

`default_nettype wire

// ----- hdl/lsfe_out_reg.sv -----
// lsfe_out_reg: result register between the decoder and the result channel.
// Depends on lsfe_pkg; takes a new result whenever the slot is empty or draining.
`default_nettype none

module lsfe_out_reg (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire lsfe_pkg::result_t  res,
  input  wire logic               load,
  output logic                    slot_free,
  lsfe_out_if.source              out_bus
);

  logic              valid_r;
  lsfe_pkg::result_t data_r;

  // free when empty or when the held beat leaves this cycle
  assign slot_free = !valid_r || out_bus.ready;

  // valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      valid_r <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= res;
    end
  end

  assign out_bus.valid = valid_r;
  assign out_bus.kind  = data_r.kind;
  assign out_bus.value = data_r.value;
  assign out_bus.last  = data_r.last;

  // a loaded result is presented next cycle
  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> valid_r)
    else $error("loaded result not presented");

  // never overwrite a beat that is still stalled
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> (!valid_r || out_bus.ready))
    else $error("result overwritten while stalled");

  // kind codes above payload byte never appear
  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> data_r.kind <= lsfe_pkg::K_PAY_BYTE)
    else $error("result kind out of range");

endmodule

`default_nettype wire

// ----- hdl/lsb_stego_frame_extractor_unit.sv -----
// lsb_stego_frame_extractor_unit: top level of the LSB stego frame extractor.
// Depends on lsfe_pkg, lsfe_if.sv, lsfe_decoder and lsfe_out_reg.
//
//   channel  | dir | beat contents
//   ---------+-----+-------------------------------------------------
//   in_bus   | in  | image_byte[7:0], first_byte
//   out_bus  | out | kind[2:0], value[31:0], last
//   cfg_*    | in  | cfg_we, cfg_index (0 magic_word, 1 header_bytes), cfg_wdata
//
// One file byte per cycle; each byte is decoded in the cycle it is accepted
// and its result, if any, sits in the output register the next cycle.
// in_bus.ready is high while the output register is empty or being drained.
// A stalled result holds the input off; bytes that make no result still need it.
// Synchronous active-low reset; no clearing pass, in_bus.ready is high once reset has emptied the output register.
`default_nettype none

module lsb_stego_frame_extractor_unit (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [lsfe_pkg::CfgIdxW-1:0]   cfg_index,
  input  wire logic [lsfe_pkg::CfgDataW-1:0]  cfg_wdata,
  lsfe_in_if.sink                             in_bus,
  lsfe_out_if.source                          out_bus
);

  lsfe_pkg::result_t res;
  logic              res_emit;
  logic              slot_free;
  logic              beat_acc;

  assign in_bus.ready = slot_free;
  assign beat_acc     = in_bus.valid && slot_free;

  // per-byte decode and parse state
  lsfe_decoder u_dec (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .beat_acc   (beat_acc),
    .image_byte (in_bus.image_byte),
    .first_byte (in_bus.first_byte),
    .res        (res),
    .res_emit   (res_emit)
  );

  // result register
  lsfe_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res       (res),
    .load      (beat_acc && res_emit),
    .slot_free (slot_free),
    .out_bus   (out_bus)
  );

endmodule

`default_nettype wire

// ----- verif/lsfe_field_checker.sv -----
// lsfe_field_checker: predicts the decoded fields of the stego extractor, checks result beats.
// Depends on lsfe_pkg and the lsfe_in_if / lsfe_out_if channel interfaces.
// It watches the config port too, so it tracks magic_word and header_bytes on its own.
module lsfe_field_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [lsfe_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [lsfe_pkg::CfgDataW-1:0]  cfg_wdata,
  lsfe_in_if                             in_mon,
  lsfe_out_if                            out_mon,
  output int                             mismatches,
  output int                             pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // Shadow copy of the registers and of the parser
  logic [15:0]       magic_cfg;
  logic [7:0]        header_cfg;
  lsfe_pkg::phase_t  phase;
  logic [7:0]        skipped;
  logic [31:0]       shift_reg;
  int unsigned       nbits;
  logic [31:0]       remaining;

  lsfe_pkg::result_t expected_fields[$];

  task automatic clear_parser();
    phase     = lsfe_pkg::PH_SKIP;
    skipped   = 8'd0;
    shift_reg = 32'd0;
    nbits     = 0;
    remaining = 32'd0;
  endtask

  // One file byte in, zero or one decoded field out
  task automatic absorb_byte(input logic [7:0] image_byte, input logic first_byte);
    int unsigned       field_w;
    logic [31:0]       word;
    logic [31:0]       len;
    lsfe_pkg::result_t res;
    if (first_byte) clear_parser();
    if (phase == lsfe_pkg::PH_SKIP) begin
      if (skipped < header_cfg) begin
        skipped++;
        return;
      end
      phase     = lsfe_pkg::PH_MAGIC;
      shift_reg = 32'd0;
      nbits     = 0;
    end
    if (phase == lsfe_pkg::PH_DONE || phase == lsfe_pkg::PH_ERROR) return;

    shift_reg = {shift_reg[30:0], image_byte[0]};
    field_w = (phase == lsfe_pkg::PH_MAGIC) ? 16 :
              (phase == lsfe_pkg::PH_EXT_LEN || phase == lsfe_pkg::PH_PAY_LEN) ? 32 : 8;
    if (nbits + 1 < field_w) begin
      nbits++;
      return;
    end
    word      = shift_reg;
    shift_reg = 32'd0;
    nbits     = 0;

    res.value = 32'd0;
    res.last  = 1'b0;
    case (phase)
      lsfe_pkg::PH_MAGIC: begin
        if (word[15:0] == magic_cfg) begin
          phase    = lsfe_pkg::PH_EXT_LEN;
          res.kind = lsfe_pkg::K_MAGIC_OK;
        end else begin
          phase    = lsfe_pkg::PH_ERROR;
          res.kind = lsfe_pkg::K_MAGIC_BAD;
          res.last = 1'b1;
        end
      end
      lsfe_pkg::PH_EXT_LEN: begin
        // top bit set means zero length
        len       = word[31] ? 32'd0 : word;
        remaining = len;
        phase     = (len == 32'd0) ? lsfe_pkg::PH_PAY_LEN : lsfe_pkg::PH_EXT_BYTES;
        res.kind  = lsfe_pkg::K_EXT_LEN;
        res.value = len;
      end
      lsfe_pkg::PH_EXT_BYTES: begin
        remaining = remaining - 32'd1;
        if (remaining == 32'd0) phase = lsfe_pkg::PH_PAY_LEN;
        res.kind  = lsfe_pkg::K_EXT_BYTE;
        res.value = {24'd0, word[7:0]};
      end
      lsfe_pkg::PH_PAY_LEN: begin
        len       = word[31] ? 32'd0 : word;
        remaining = len;
        phase     = (len == 32'd0) ? lsfe_pkg::PH_DONE : lsfe_pkg::PH_PAY_BYTES;
        res.kind  = lsfe_pkg::K_PAY_LEN;
        res.value = len;
      end
      default: begin
        remaining = remaining - 32'd1;
        if (remaining == 32'd0) begin
          phase    = lsfe_pkg::PH_DONE;
          res.last = 1'b1;
        end
        res.kind  = lsfe_pkg::K_PAY_BYTE;
        res.value = {24'd0, word[7:0]};
      end
    endcase
    expected_fields.push_back(res);
  endtask

  // Sample everything at the rising edge
  always @(posedge clk) begin
    lsfe_pkg::result_t want;
    if (!rst_n) begin
      magic_cfg  = lsfe_pkg::MAGIC_RESET;
      header_cfg = lsfe_pkg::HEADER_RESET;
      clear_parser();
      expected_fields.delete();
      mismatches = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          lsfe_pkg::CFG_MAGIC_WORD:   magic_cfg  = cfg_wdata[15:0];
          lsfe_pkg::CFG_HEADER_BYTES: header_cfg = cfg_wdata[7:0];
          default: ;
        endcase
      end

      // result beat against the oldest prediction
      if (out_mon.valid && out_mon.ready) begin
        if (expected_fields.size() == 0) begin
          $error("result beat with nothing predicted: kind=%0d value=%0h last=%0b",
                 out_mon.kind, out_mon.value, out_mon.last);
          mismatches++;
        end else begin
          want = expected_fields.pop_front();
          if (out_mon.kind !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, out_mon.kind);
            mismatches++;
          end
          if (out_mon.value !== want.value) begin
            $error("value: expected %0h, got %0h", want.value, out_mon.value);
            mismatches++;
          end
          if (out_mon.last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, out_mon.last);
            mismatches++;
          end
        end
      end

      if (in_mon.valid && in_mon.ready)
        absorb_byte(in_mon.image_byte, in_mon.first_byte);
    end
    pending = expected_fields.size();
  end

endmodule

// ----- verif/lsb_stego_frame_extractor_unit_test.sv -----
// lsb_stego_frame_extractor_unit_test: stimulus and verdict for the LSB stego frame extractor.
// Depends on lsfe_pkg, lsfe_if.sv, the extractor RTL and lsfe_field_checker.
// Sends whole stego files, broken files and noise under several configs, with random stalls.
module lsb_stego_frame_extractor_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT  = 3000;
  localparam int HOLD_CYCLES  = 400;
  localparam int RANDOM_BEATS = 250;

  logic                           clk;
  logic                           rst_n;
  logic                           cfg_we;
  logic [lsfe_pkg::CfgIdxW-1:0]   cfg_index;
  logic [lsfe_pkg::CfgDataW-1:0]  cfg_wdata;

  lsfe_in_if  in_bus();
  lsfe_out_if out_bus();

  int          mismatches;
  int          pending;
  int          beats_sent;
  bit          steady;
  bit          hold_req;
  logic [15:0] magic_now;
  logic [7:0]  hdr_now;

  lsb_stego_frame_extractor_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_bus    (in_bus),
    .out_bus   (out_bus)
  );

  lsfe_field_checker u_field_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_mon     (in_bus),
    .out_mon    (out_bus),
    .mismatches (mismatches),
    .pending    (pending)
  );

  // 8 ns clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Result side: random stalls, a no-stall stretch, one long hold-off on request
  initial begin
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      out_bus.ready <= steady || ($urandom_range(99) >= 30);
    end
  end

  // Watchdog: too long without any beat on either channel
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) quiet = 0;
      else quiet++;
    end
    $display("lsb_stego_frame_extractor_unit_test: FAIL");
    $finish;
  end

  // One file byte, with an optional gap before it
  task automatic push_byte(input logic [7:0] image_byte, input logic first_byte);
    if (!steady && $urandom_range(99) < 30) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_bus.valid      <= 1'b1;
    in_bus.image_byte <= image_byte;
    in_bus.first_byte <= first_byte;
    do @(posedge clk); while (!in_bus.ready);
    beats_sent++;
  endtask

  // Stop sending and wait until every predicted field has drained
  task automatic settle();
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic load_config(input logic [15:0] magic, input logic [7:0] hdr);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= lsfe_pkg::CFG_MAGIC_WORD;
    cfg_wdata <= magic;
    @(posedge clk);
    cfg_index <= lsfe_pkg::CFG_HEADER_BYTES;
    cfg_wdata <= {8'h00, hdr};
    @(posedge clk);
    cfg_we    <= 1'b0;
    magic_now = magic;
    hdr_now   = hdr;
  endtask

  function automatic void put_bits(ref bit q[$], input logic [31:0] v, input int n);
    for (int i = n - 1; i >= 0; i--) q.push_back(v[i]);
  endfunction

  // Header bytes only; the first one may open a new file
  task automatic skip_bytes(input int n, input bit fresh);
    for (int i = 0; i < n; i++) push_byte(8'($urandom), fresh && i == 0);
  endtask

  // A hidden file: magic, ext length, ext bytes, payload length, payload bytes.
  // keep < 0 sends every bit, else the file is cut after keep bits.
  task automatic send_file(input logic [15:0] magic, input logic [31:0] ext_len,
                           input logic [31:0] pay_len, input int keep, input bit fresh);
    bit          hidden_bits[$];
    logic [7:0]  carrier;
    int unsigned n_ext;
    int unsigned n_pay;
    int          n_sent;
    n_ext = ext_len[31] ? 0 : ((ext_len > 6) ? 6 : ext_len);
    n_pay = pay_len[31] ? 0 : ((pay_len > 6) ? 6 : pay_len);
    put_bits(hidden_bits, {16'd0, magic}, 16);
    put_bits(hidden_bits, ext_len, 32);
    repeat (n_ext) put_bits(hidden_bits, $urandom, 8);
    put_bits(hidden_bits, pay_len, 32);
    repeat (n_pay) put_bits(hidden_bits, $urandom, 8);
    n_sent = (keep < 0 || keep > hidden_bits.size()) ? hidden_bits.size() : keep;
    if (fresh) skip_bytes(int'(hdr_now), 1'b1);
    for (int i = 0; i < n_sent; i++) begin
      carrier = 8'($urandom);
      push_byte({carrier[7:1], hidden_bits[i]}, fresh && hdr_now == 8'd0 && i == 0);
    end
  endtask

  // Mostly short lengths, some zero, some negative, some far too long
  function automatic logic [31:0] pick_length();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(9))
      0, 1, 2: return 32'd0;
      3, 4, 5, 6: return $urandom_range(1, 4);
      7: return {1'b1, r[30:0]};
      8: return {1'b0, r[30:0]};
      default: return $urandom_range(5, 6);
    endcase
  endfunction

  // Stimulus
  initial begin
    int          start_beats;
    int          roll;
    logic [15:0] magic;
    int          keep;

    rst_n             <= 1'b0;
    in_bus.valid      <= 1'b0;
    in_bus.image_byte <= 8'h00;
    in_bus.first_byte <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_index         <= lsfe_pkg::CFG_MAGIC_WORD;
    cfg_wdata         <= '0;
    beats_sent = 0;
    steady     = 1'b0;
    hold_req   = 1'b0;
    magic_now  = lsfe_pkg::MAGIC_RESET;
    hdr_now    = lsfe_pkg::HEADER_RESET;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset config: full file, then bytes after the end are ignored
    send_file(lsfe_pkg::MAGIC_RESET, 32'd1, 32'd2, -1, 1'b1);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);

    // empty header, all-ones magic, negative ext length, zero payload length
    load_config(16'hFFFF, 8'd0);
    send_file(16'hFFFF, 32'hFFFF_FFFF, 32'd0, -1, 1'b1);
    // zero ext length, negative payload length
    send_file(16'hFFFF, 32'd0, 32'h8000_0000, -1, 1'b1);
    // magic mismatch, rest of file ignored; receiver holds off so the input stalls
    hold_req = 1'b1;
    send_file(16'hFFFE, 32'd0, 32'd1, -1, 1'b1);
    // restart in the middle of the ext length, then inside ext bytes
    send_file(16'hFFFF, 32'h7FFF_FFFF, 32'd0, 40, 1'b1);
    send_file(16'hFFFF, 32'h7FFF_FFFF, 32'd0, 64, 1'b1);

    // longest header, all-zero magic, sent with no idling on either side
    load_config(16'h0000, 8'd255);
    steady = 1'b1;
    send_file(16'h0000, 32'd0, 32'd1, -1, 1'b1);
    steady = 1'b0;

    // header length lowered while skipping: data starts at once
    load_config(16'h5A3C, 8'd10);
    skip_bytes(5, 1'b1);
    load_config(16'h5A3C, 8'd3);
    send_file(16'h5A3C, 32'd2, 32'd1, -1, 1'b0);
    // header length raised while skipping
    load_config(16'hA5C3, 8'd2);
    skip_bytes(1, 1'b1);
    load_config(16'hA5C3, 8'd6);
    skip_bytes(5, 1'b0);
    send_file(16'hA5C3, 32'd1, 32'd1, -1, 1'b0);

    load_config(16'($urandom), 8'($urandom_range(0, 8)));

    // random part: mostly well-formed files with random content
    start_beats = beats_sent;
    while (beats_sent - start_beats < RANDOM_BEATS) begin
      roll = $urandom_range(99);
      if (roll < 10) begin
        case ($urandom_range(3))
          0: load_config(16'h0000, 8'd0);
          1: load_config(16'hFFFF, 8'($urandom_range(0, 12)));
          default: load_config(16'($urandom),
                               ($urandom_range(3) == 0) ? 8'd0 : 8'($urandom_range(1, 12)));
        endcase
      end else if (roll < 25) begin
        // noise with the odd restart
        repeat ($urandom_range(4, 24)) push_byte(8'($urandom), $urandom_range(15) == 0);
      end else begin
        magic = magic_now;
        if ($urandom_range(9) == 0) magic[$urandom_range(15)] = ~magic[$urandom_range(15)];
        if ($urandom_range(9) == 0) magic = ~magic;
        keep = ($urandom_range(9) == 0) ? int'($urandom_range(0, 120)) : -1;
        send_file(magic, pick_length(), pick_length(), keep, 1'b1);
        if ($urandom_range(4) == 0) repeat ($urandom_range(1, 4)) push_byte(8'($urandom), 1'b0);
      end
    end

    // drain, then verdict
    settle();
    repeat (5) @(posedge clk);
    if (mismatches == 0) begin
      $display("lsb_stego_frame_extractor_unit_test: PASS");
    end else begin
      $display("lsb_stego_frame_extractor_unit_test: FAIL");
    end
    $finish;
  end

endmodule
